### rtl/binned_histogram_engine_macros.svh
// ----------------------------------------------------------------------------
// Binned histogram engine assertion macros
// Shared concurrent assertion shorthands, clocked on clock, gated by reset.
// ----------------------------------------------------------------------------
`ifndef BINNED_HISTOGRAM_ENGINE_MACROS_SVH
`define BINNED_HISTOGRAM_ENGINE_MACROS_SVH

// Same-cycle implication.
`define BHE_ASSERT_IMP(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("binned_histogram_engine: assertion failed");

// Next-cycle implication.
`define BHE_ASSERT_NXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("binned_histogram_engine: assertion failed");

`endif

### rtl/bhe_pkg.sv
// ----------------------------------------------------------------------------
// Binned histogram engine package
// Field widths, request and register codes, defaults and transaction types.
// ----------------------------------------------------------------------------
package bhe_pkg;

   localparam int REQ_W       = 2;
   localparam int VALUE_W     = 16;
   localparam int QUERY_W     = 9;
   localparam int BINS_W      = 9;
   localparam int PCT_W       = 15;
   localparam int OUT_COUNT_W = 32;
   localparam int PEAK_BIN_W  = 8;
   localparam int CSR_IDX_W   = 2;
   localparam int CSR_DATA_W  = 16;
   localparam int PCT_STEPS   = 16;

   localparam int DEF_MAX_BINS    = 256;
   localparam int DEF_SAMPLE_BITS = 16;
   localparam int DEF_COUNT_BITS  = 32;

   localparam logic [REQ_W-1:0] REQ_ADD   = 2'd0;
   localparam logic [REQ_W-1:0] REQ_QUERY = 2'd1;
   localparam logic [REQ_W-1:0] REQ_CLEAR = 2'd2;

   localparam logic [CSR_IDX_W-1:0] CSR_BINS_IN_USE = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_RANGE_LOW   = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_RANGE_HIGH  = 2'd2;

   localparam logic [BINS_W-1:0]  RST_BINS_IN_USE = 9'd256;
   localparam logic [VALUE_W-1:0] RST_RANGE_LOW   = 16'd0;
   localparam logic [VALUE_W-1:0] RST_RANGE_HIGH  = 16'd256;

   // Percent scale in Q7.8: 100 * 256.
   localparam logic [PCT_STEPS-1:0] PCT_SCALE = 16'd25600;

   typedef struct packed {
      logic [REQ_W-1:0]   req_type;
      logic [VALUE_W-1:0] sample_value;
      logic [QUERY_W-1:0] query_bin;
   } req_item_type;

   typedef struct packed {
      logic [QUERY_W-1:0]     target_bin;
      logic [OUT_COUNT_W-1:0] bin_count;
      logic [OUT_COUNT_W-1:0] total_count;
      logic [PCT_W-1:0]       forward_percent;
      logic [PCT_W-1:0]       backward_percent;
      logic                   percent_valid;
      logic [OUT_COUNT_W-1:0] peak_count;
      logic [PEAK_BIN_W-1:0]  peak_bin;
      logic [OUT_COUNT_W-1:0] trough_count;
      logic [PEAK_BIN_W-1:0]  trough_bin;
      logic [VALUE_W-1:0]     bin_low_edge;
   } rsp_item_type;

endpackage

### rtl/bhe_ram.sv
// ----------------------------------------------------------------------------
// Generic single-port-write RAM
// One write port and one read port; read data is registered.
// ----------------------------------------------------------------------------
module bhe_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### rtl/bhe_divider.sv
// ----------------------------------------------------------------------------
// Restoring divider
// Unsigned quotient, one bit per cycle; done pulses when the quotient is ready.
// ----------------------------------------------------------------------------
module bhe_divider #(
   parameter int NW = 26,
   parameter int DW = 16
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          start,
   input  logic [NW-1:0] numer,
   input  logic [DW-1:0] denom,
   output logic          done,
   output logic [NW-1:0] quot
);

   localparam int CNT_W = $clog2(NW + 1);

   logic             run_ff, run_in;
   logic             done_ff, done_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [NW-1:0]    quo_ff, quo_in;
   logic [DW-1:0]    rem_ff, rem_in;
   logic [DW-1:0]    den_ff, den_in;
   logic [DW:0]      rem_sh;
   logic             ge;

   always_comb begin
      rem_sh  = {rem_ff, quo_ff[NW-1]};
      ge      = (rem_sh >= {1'b0, den_ff});
      run_in  = run_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      if (start) begin
         run_in = 1'b1;
         cnt_in = CNT_W'(NW);
         quo_in = numer;
         rem_in = '0;
         den_in = denom;
      end else if (run_ff) begin
         rem_in = ge ? DW'(rem_sh - {1'b0, den_ff}) : rem_sh[DW-1:0];
         quo_in = {quo_ff[NW-2:0], ge};
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CNT_W'(1)) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
   end

   assign done = done_ff;
   assign quot = quo_ff;

endmodule

### rtl/binned_histogram_engine.sv
// ----------------------------------------------------------------------------
// Binned histogram engine
// Counts samples into a binned histogram held in RAM and answers bin queries.
// ----------------------------------------------------------------------------
// A transaction is accepted when start is high and busy is low; it is one of
// add sample, query bin or clear. Each transaction yields exactly one result,
// shown on rsp_item for a single cycle with rsp_valid high. The receiver
// cannot hold results off, so it must take each one in that cycle. The result
// appears in the cycle in which busy drops, and a new transaction may be
// accepted at the edge that ends it. An add of a sample inside the range
// runs the shared one-bit-per-cycle divider, of numerator width NW, that
// maps the sample onto its bin. A sample outside the range, or equal range
// limits, skips the divider. A query reads every bin in use (the effective
// bin count) from the count RAM once, one entry per cycle, then forms both
// percentages sixteen steps long and the lower bin edge on the divider. A
// clear, or an unused request code, is answered from the clear state, but
// only a clear, or a write to one of the three registers, empties the
// histogram at once: per-entry valid bits mark which RAM entries hold a
// count, so no clearing pass runs after reset. Register writes must happen
// only while busy is low.
// ----------------------------------------------------------------------------
module binned_histogram_engine import bhe_pkg::*; #(
   parameter int MAX_BINS    = DEF_MAX_BINS,
   parameter int SAMPLE_BITS = DEF_SAMPLE_BITS,
   parameter int COUNT_BITS  = DEF_COUNT_BITS
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   output logic                  busy,
   input  req_item_type          req_item,
   output logic                  rsp_valid,
   output rsp_item_type          rsp_item,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

`include "binned_histogram_engine_macros.svh"

   localparam int AW   = $clog2(MAX_BINS);
   localparam int NB_W = $clog2(MAX_BINS + 1);
   localparam int XW   = (NB_W > QUERY_W) ? NB_W : QUERY_W;
   localparam int CW   = COUNT_BITS;
   localparam int SW   = CW + NB_W;
   localparam int NW   = XW + VALUE_W + 1;
   localparam int DW   = (NB_W > VALUE_W) ? NB_W : VALUE_W;
   localparam int EQ_W = QUERY_W + VALUE_W + 1;
   localparam int EW   = ((SAMPLE_BITS > EQ_W) ? SAMPLE_BITS : EQ_W) + 2;
   localparam int BW   = $clog2(PCT_STEPS);

   localparam logic [VALUE_W-1:0] V_MASK = (SAMPLE_BITS >= VALUE_W) ? '1 :
                                           VALUE_W'((1 << SAMPLE_BITS) - 1);
   localparam logic [CW-1:0] CMAX = '1;

   localparam logic [3:0] S_IDLE      = 4'd0;
   localparam logic [3:0] S_ADD_GO    = 4'd1;
   localparam logic [3:0] S_ADD_WAIT  = 4'd2;
   localparam logic [3:0] S_ADD_RD    = 4'd3;
   localparam logic [3:0] S_ADD_WR    = 4'd4;
   localparam logic [3:0] S_WALK      = 4'd5;
   localparam logic [3:0] S_TAIL      = 4'd6;
   localparam logic [3:0] S_PCT_INIT  = 4'd7;
   localparam logic [3:0] S_PCT       = 4'd8;
   localparam logic [3:0] S_EDGE_GO   = 4'd9;
   localparam logic [3:0] S_EDGE_WAIT = 4'd10;
   localparam logic [3:0] S_CLEAR     = 4'd11;

   function automatic logic [OUT_COUNT_W-1:0] cnt_out(input logic [CW-1:0] x);
      logic [CW+OUT_COUNT_W-1:0] t;
      t = (CW + OUT_COUNT_W)'(x);
      return t[OUT_COUNT_W-1:0];
   endfunction

   function automatic logic [QUERY_W-1:0] bin9_out(input logic [AW-1:0] x);
      logic [AW+QUERY_W-1:0] t;
      t = (AW + QUERY_W)'(x);
      return t[QUERY_W-1:0];
   endfunction

   function automatic logic [PEAK_BIN_W-1:0] bin8_out(input logic [AW-1:0] x);
      logic [AW+PEAK_BIN_W-1:0] t;
      t = (AW + PEAK_BIN_W)'(x);
      return t[PEAK_BIN_W-1:0];
   endfunction

   // Configuration registers and global state.
   logic [3:0]         state_ff, state_in;
   logic [BINS_W-1:0]  bins_ff;
   logic [VALUE_W-1:0] range_low_ff, range_high_ff;
   logic [CW-1:0]      total_ff, total_in;
   logic [MAX_BINS-1:0] valid_ff;
   logic               store_clear;
   logic               csr_hit;

   // Effective bin count: zero reads as one, anything above MAX_BINS as MAX_BINS.
   logic [XW-1:0]   bins_x, nb_x;
   logic [NB_W-1:0] nb, nb_m1;

   assign bins_x = XW'(bins_ff);
   assign nb_x   = (bins_x == '0) ? XW'(1) :
                   (bins_x > XW'(MAX_BINS)) ? XW'(MAX_BINS) : bins_x;
   assign nb     = nb_x[NB_W-1:0];
   assign nb_m1  = nb - 1'b1;

   // Request decode at acceptance.
   logic               accept;
   logic [VALUE_W-1:0] v_m, v_diff;
   logic [NW-1:0]      add_prod;
   logic signed [EQ_W:0] q_s, diff_s, prod_s, mag_s;
   logic [EQ_W-1:0]    edge_mag;

   assign accept   = start && !busy;
   assign v_m      = req_item.sample_value & V_MASK;
   assign v_diff   = v_m - range_low_ff;
   assign add_prod = NW'(nb_m1) * NW'(v_diff);
   assign q_s      = signed'((EQ_W + 1)'(req_item.query_bin));
   assign diff_s   = signed'((EQ_W + 1)'(range_high_ff)) -
                     signed'((EQ_W + 1)'(range_low_ff));
   assign prod_s   = q_s * diff_s;
   // A negative product must round downward, so its magnitude rounds up.
   assign mag_s    = prod_s[EQ_W] ? (-prod_s + signed'((EQ_W + 1)'(nb_m1))) : prod_s;
   assign edge_mag = mag_s[EQ_W-1:0];

   // Per-transaction registers.
   logic [QUERY_W-1:0] q_ff;
   logic [AW-1:0]      idx_ff;
   logic [NW-1:0]      div_num_ff;
   logic [DW-1:0]      div_den_ff;
   logic               edge_neg_ff;
   logic               div_start, div_done;
   logic [NW-1:0]      div_quot;

   bhe_divider #(
      .NW (NW),
      .DW (DW)
   ) u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .numer (div_num_ff),
      .denom (div_den_ff),
      .done  (div_done),
      .quot  (div_quot)
   );

   assign div_start = (state_ff == S_ADD_GO) || (state_ff == S_EDGE_GO);

   // Count RAM.
   logic          ram_wr_en, ram_rd_en;
   logic [AW-1:0] ram_rd_addr;
   logic [CW-1:0] ram_rd_data, ram_wr_data;
   logic [NB_W-1:0] walk_ff;

   bhe_ram #(
      .WIDTH (CW),
      .DEPTH (MAX_BINS)
   ) u_counts (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (idx_ff),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   assign ram_rd_en   = (state_ff == S_WALK) || (state_ff == S_ADD_RD);
   assign ram_rd_addr = (state_ff == S_WALK) ? walk_ff[AW-1:0] : idx_ff;

   // Add: read-modify-write of one bin, saturating.
   logic [CW-1:0] cnt_old, cnt_new;
   logic          cnt_sat;

   assign cnt_old     = valid_ff[idx_ff] ? ram_rd_data : '0;
   assign cnt_sat     = (cnt_old == CMAX);
   assign cnt_new     = cnt_sat ? cnt_old : cnt_old + 1'b1;
   assign ram_wr_en   = (state_ff == S_ADD_WR);
   assign ram_wr_data = cnt_new;

   always_comb begin
      total_in = total_ff;
      if (store_clear) begin
         total_in = '0;
      end else if (ram_wr_en && !cnt_sat && (total_ff != CMAX)) begin
         total_in = total_ff + 1'b1;
      end
   end

   // Query walk: one RAM entry per cycle, accumulated in the cycle after its read.
   logic            rd_vld_ff;
   logic [NB_W-1:0] rd_idx_ff;
   logic [CW-1:0]   walk_cnt;
   logic [SW-1:0]   sum_ff, below_ff;
   logic [CW-1:0]   pk_ff, tr_ff, qcnt_ff;
   logic [AW-1:0]   pkb_ff, trb_ff;
   logic            first_elem;

   assign walk_cnt   = valid_ff[rd_idx_ff[AW-1:0]] ? ram_rd_data : '0;
   assign first_elem = (rd_idx_ff == '0);

   always_ff @(posedge clock) begin
      if (accept) begin
         sum_ff   <= '0;
         below_ff <= '0;
         qcnt_ff  <= '0;
      end else if (rd_vld_ff) begin
         sum_ff <= sum_ff + SW'(walk_cnt);
         if (XW'(rd_idx_ff) < XW'(q_ff)) begin
            below_ff <= below_ff + SW'(walk_cnt);
         end
         if (XW'(rd_idx_ff) == XW'(q_ff)) begin
            qcnt_ff <= walk_cnt;
         end
         if (first_elem || (walk_cnt > pk_ff)) begin
            pk_ff  <= walk_cnt;
            pkb_ff <= rd_idx_ff[AW-1:0];
         end
         if (first_elem || (walk_cnt < tr_ff)) begin
            tr_ff  <= walk_cnt;
            trb_ff <= rd_idx_ff[AW-1:0];
         end
      end
   end

   // Percentages: floor(25600 * a / sum), one scale bit per cycle for both lanes.
   logic            pv_ff;
   logic [BW-1:0]   bit_ff;
   logic [SW:0]     r_ff [2];
   logic [SW:0]     a_ff [2];
   logic [PCT_STEPS-1:0] pq_ff [2];
   logic [SW:0]     r_nx [2];
   logic [PCT_STEPS-1:0] pq_nx [2];
   logic [SW:0]     sum_x;

   assign sum_x = (SW + 1)'(sum_ff);

   always_comb begin
      logic [SW:0] r1;
      logic [PCT_STEPS-1:0] p1;
      for (int l = 0; l < 2; l++) begin
         r1 = {r_ff[l][SW-1:0], 1'b0};
         p1 = {pq_ff[l][PCT_STEPS-2:0], 1'b0};
         if (r1 >= sum_x) begin
            r1 = r1 - sum_x;
            p1 = p1 + 1'b1;
         end
         if (PCT_SCALE[bit_ff]) begin
            r1 = r1 + a_ff[l];
            if (r1 >= sum_x) begin
               r1 = r1 - sum_x;
               p1 = p1 + 1'b1;
            end
         end
         r_nx[l]  = r1;
         pq_nx[l] = p1;
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == S_PCT_INIT) begin
         pv_ff    <= (XW'(q_ff) <= nb_x) && (sum_ff != '0);
         bit_ff   <= BW'(PCT_STEPS - 1);
         r_ff[0]  <= '0;
         r_ff[1]  <= '0;
         pq_ff[0] <= '0;
         pq_ff[1] <= '0;
         a_ff[0]  <= (SW + 1)'(below_ff);
         a_ff[1]  <= (SW + 1)'(sum_ff - below_ff);
      end else if (state_ff == S_PCT) begin
         bit_ff   <= bit_ff - 1'b1;
         r_ff[0]  <= r_nx[0];
         r_ff[1]  <= r_nx[1];
         pq_ff[0] <= pq_nx[0];
         pq_ff[1] <= pq_nx[1];
      end
   end

   // Lower bin edge from the divider quotient, clamped to the sample range.
   logic signed [EW-1:0] step_s, edge_s, edge_cl;
   localparam logic signed [EW-1:0] EDGE_MAX = signed'(EW'({SAMPLE_BITS{1'b1}}));

   always_comb begin
      step_s = signed'(EW'(div_quot[EQ_W-1:0]));
      if (edge_neg_ff) begin
         step_s = -step_s;
      end
      edge_s  = signed'(EW'(range_low_ff)) + step_s;
      edge_cl = edge_s;
      if (edge_s < 0) begin
         edge_cl = '0;
      end else if (edge_s > EDGE_MAX) begin
         edge_cl = EDGE_MAX;
      end
   end

   // Sequencer.
   logic         rsp_valid_ff, rsp_valid_in;
   rsp_item_type rsp_item_ff, rsp_item_in;

   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = 1'b0;
      rsp_item_in  = '0;
      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               case (req_item.req_type)
                  REQ_ADD: begin
                     if ((v_m < range_low_ff) || (v_m > range_high_ff) ||
                         (range_high_ff == range_low_ff)) begin
                        state_in = S_ADD_RD;
                     end else begin
                        state_in = S_ADD_GO;
                     end
                  end
                  REQ_QUERY: begin
                     state_in = S_WALK;
                  end
                  default: begin
                     state_in = S_CLEAR;
                  end
               endcase
            end
         end
         S_ADD_GO: begin
            state_in = S_ADD_WAIT;
         end
         S_ADD_WAIT: begin
            if (div_done) begin
               state_in = S_ADD_RD;
            end
         end
         S_ADD_RD: begin
            state_in = S_ADD_WR;
         end
         S_ADD_WR: begin
            state_in                = S_IDLE;
            rsp_valid_in            = 1'b1;
            rsp_item_in.target_bin  = bin9_out(idx_ff);
            rsp_item_in.bin_count   = cnt_out(cnt_new);
            rsp_item_in.total_count = cnt_out(total_in);
         end
         S_WALK: begin
            if (walk_ff == nb_m1) begin
               state_in = S_TAIL;
            end
         end
         S_TAIL: begin
            state_in = S_PCT_INIT;
         end
         S_PCT_INIT: begin
            state_in = S_PCT;
         end
         S_PCT: begin
            if (bit_ff == '0) begin
               state_in = S_EDGE_GO;
            end
         end
         S_EDGE_GO: begin
            state_in = S_EDGE_WAIT;
         end
         S_EDGE_WAIT: begin
            if (div_done) begin
               state_in                     = S_IDLE;
               rsp_valid_in                 = 1'b1;
               rsp_item_in.target_bin       = q_ff;
               rsp_item_in.bin_count        = cnt_out(qcnt_ff);
               rsp_item_in.total_count      = cnt_out(total_ff);
               rsp_item_in.forward_percent  = pv_ff ? pq_ff[0][PCT_W-1:0] : '0;
               rsp_item_in.backward_percent = pv_ff ? pq_ff[1][PCT_W-1:0] : '0;
               rsp_item_in.percent_valid    = pv_ff;
               rsp_item_in.peak_count       = cnt_out(pk_ff);
               rsp_item_in.peak_bin         = bin8_out(pkb_ff);
               rsp_item_in.trough_count     = cnt_out(tr_ff);
               rsp_item_in.trough_bin       = bin8_out(trb_ff);
               rsp_item_in.bin_low_edge     = edge_cl[VALUE_W-1:0];
            end
         end
         S_CLEAR: begin
            state_in     = S_IDLE;
            rsp_valid_in = 1'b1;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // A write to any of the three registers, or a clear transaction, empties the histogram.
   assign csr_hit     = csr_we && ((csr_index == CSR_BINS_IN_USE) ||
                                   (csr_index == CSR_RANGE_LOW) ||
                                   (csr_index == CSR_RANGE_HIGH));
   assign store_clear = csr_hit || (accept && (req_item.req_type == REQ_CLEAR));

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         bins_ff       <= RST_BINS_IN_USE;
         range_low_ff  <= RST_RANGE_LOW;
         range_high_ff <= RST_RANGE_HIGH;
         total_ff      <= '0;
         valid_ff      <= '0;
         rsp_valid_ff  <= 1'b0;
         rd_vld_ff     <= 1'b0;
      end else begin
         state_ff     <= state_in;
         total_ff     <= total_in;
         rsp_valid_ff <= rsp_valid_in;
         rd_vld_ff    <= (state_ff == S_WALK);
         if (csr_we) begin
            case (csr_index)
               CSR_BINS_IN_USE: bins_ff       <= csr_wdata[BINS_W-1:0];
               CSR_RANGE_LOW:   range_low_ff  <= csr_wdata;
               CSR_RANGE_HIGH:  range_high_ff <= csr_wdata;
               default: begin
               end
            endcase
         end
         if (store_clear) begin
            valid_ff <= '0;
         end else if (ram_wr_en) begin
            valid_ff[idx_ff] <= 1'b1;
         end
      end
   end

   // Datapath registers without reset.
   always_ff @(posedge clock) begin
      rsp_item_ff <= rsp_item_in;
      rd_idx_ff   <= walk_ff;
      if (state_ff == S_WALK) begin
         walk_ff <= walk_ff + 1'b1;
      end
      if (accept) begin
         q_ff    <= req_item.query_bin;
         walk_ff <= '0;
         if (req_item.req_type == REQ_QUERY) begin
            div_num_ff  <= NW'(edge_mag);
            div_den_ff  <= DW'(nb);
            edge_neg_ff <= prod_s[EQ_W];
         end else begin
            div_num_ff <= add_prod;
            div_den_ff <= DW'(range_high_ff - range_low_ff);
            if (v_m < range_low_ff) begin
               idx_ff <= '0;
            end else if (v_m > range_high_ff) begin
               idx_ff <= nb_m1[AW-1:0];
            end else begin
               idx_ff <= '0;
            end
         end
      end else if ((state_ff == S_ADD_WAIT) && div_done) begin
         idx_ff <= div_quot[AW-1:0];
      end
   end

   assign busy      = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_item_ff;

   // A result lasts one cycle and is only issued once the engine is free again.
   `BHE_ASSERT_NXT(a_rsp_single, rsp_valid, !rsp_valid)
   `BHE_ASSERT_IMP(a_rsp_idle, rsp_valid, !busy)
   `BHE_ASSERT_NXT(a_accept_busy, start && !busy, busy)
   `BHE_ASSERT_IMP(a_pct_invalid_zero, rsp_valid && !rsp_item.percent_valid,
                   (rsp_item.forward_percent == '0) && (rsp_item.backward_percent == '0))

endmodule

### tb/bhe_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Binned histogram engine checker
// Watches the request, result and register ports, keeps its own histogram
// and compares every result with the oldest predicted one.
// ----------------------------------------------------------------------------
module bhe_checker import bhe_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  logic                  busy,
   input  req_item_type          req_item,
   input  logic                  rsp_valid,
   input  rsp_item_type          rsp_item,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   output int                    fail_count,
   output int                    pending
);

   localparam int NBINS = DEF_MAX_BINS;
   localparam longint unsigned CNT_MAX = 64'hFFFF_FFFF;

   longint unsigned hist [NBINS];
   longint unsigned grand_total;
   logic [BINS_W-1:0]  bins_reg;
   logic [VALUE_W-1:0] lo_reg;
   logic [VALUE_W-1:0] hi_reg;
   rsp_item_type       expected_q [$];

   initial fail_count = 0;
   assign pending = expected_q.size();

   task automatic empty_hist();
      foreach (hist[i]) hist[i] = 0;
      grand_total = 0;
   endtask

   // Computes the result of one transaction and updates the histogram.
   task automatic histogram_step(input req_item_type rq, output rsp_item_type rs);
      longint unsigned nb, idx, v, sum, below, pk, tr, pkb, trb, c;
      longint signed diff, prod, step, edge_v;
      rs = '0;
      nb = (bins_reg == 0) ? 1 : (bins_reg > NBINS) ? NBINS : bins_reg;
      case (rq.req_type)
         REQ_ADD: begin
            v = rq.sample_value;
            if (v < lo_reg) idx = 0;
            else if (v > hi_reg) idx = nb - 1;
            else if (hi_reg == lo_reg) idx = 0;
            else idx = ((nb - 1) * (v - lo_reg)) / (hi_reg - lo_reg);
            if (idx >= nb) idx = nb - 1;
            if (hist[idx] < CNT_MAX) begin
               hist[idx]++;
               if (grand_total < CNT_MAX) grand_total++;
            end
            rs.target_bin  = idx[QUERY_W-1:0];
            rs.bin_count   = hist[idx][31:0];
            rs.total_count = grand_total[31:0];
         end
         REQ_QUERY: begin
            sum = 0; below = 0; pkb = 0; trb = 0;
            pk = hist[0]; tr = hist[0];
            for (int i = 0; i < nb; i++) begin
               c = hist[i];
               sum += c;
               if (i < rq.query_bin) below += c;
               if (c > pk) begin pk = c; pkb = i; end
               if (c < tr) begin tr = c; trb = i; end
            end
            rs.target_bin  = rq.query_bin;
            rs.bin_count   = (rq.query_bin < nb) ? hist[rq.query_bin][31:0] : '0;
            rs.total_count = grand_total[31:0];
            if (rq.query_bin <= nb && sum != 0) begin
               rs.forward_percent  = PCT_W'((below * 25600) / sum);
               rs.backward_percent = PCT_W'(((sum - below) * 25600) / sum);
               rs.percent_valid    = 1'b1;
            end
            rs.peak_count   = pk[31:0];
            rs.peak_bin     = pkb[7:0];
            rs.trough_count = tr[31:0];
            rs.trough_bin   = trb[7:0];
            // Floor division, so a negative span rounds the edge downward.
            diff = longint'(hi_reg) - longint'(lo_reg);
            prod = longint'(rq.query_bin) * diff;
            if (prod >= 0) step = prod / longint'(nb);
            else step = -((-prod + longint'(nb) - 1) / longint'(nb));
            edge_v = longint'(lo_reg) + step;
            if (edge_v < 0) edge_v = 0;
            if (edge_v > 65535) edge_v = 65535;
            rs.bin_low_edge = edge_v[15:0];
         end
         REQ_CLEAR: empty_hist();
         default: ;
      endcase
   endtask

   task automatic check_field(input string name, input longint unsigned exp_v,
                              input longint unsigned act_v);
      if (exp_v != act_v) begin
         $error("%s: expected %0d, got %0d", name, exp_v, act_v);
         fail_count++;
      end
   endtask

   always @(posedge clock) begin
      rsp_item_type exp_r, new_r;
      if (reset) begin
         bins_reg = RST_BINS_IN_USE;
         lo_reg   = RST_RANGE_LOW;
         hi_reg   = RST_RANGE_HIGH;
         empty_hist();
         expected_q.delete();
      end else begin
         if (csr_we) begin
            case (csr_index)
               CSR_BINS_IN_USE: begin bins_reg = csr_wdata[BINS_W-1:0]; empty_hist(); end
               CSR_RANGE_LOW:   begin lo_reg = csr_wdata; empty_hist(); end
               CSR_RANGE_HIGH:  begin hi_reg = csr_wdata; empty_hist(); end
               default: ;
            endcase
         end
         if (rsp_valid) begin
            if (expected_q.size() == 0) begin
               $error("result transaction with no request outstanding");
               fail_count++;
            end else begin
               exp_r = expected_q.pop_front();
               check_field("target_bin", exp_r.target_bin, rsp_item.target_bin);
               check_field("bin_count", exp_r.bin_count, rsp_item.bin_count);
               check_field("total_count", exp_r.total_count, rsp_item.total_count);
               check_field("forward_percent", exp_r.forward_percent,
                           rsp_item.forward_percent);
               check_field("backward_percent", exp_r.backward_percent,
                           rsp_item.backward_percent);
               check_field("percent_valid", exp_r.percent_valid, rsp_item.percent_valid);
               check_field("peak_count", exp_r.peak_count, rsp_item.peak_count);
               check_field("peak_bin", exp_r.peak_bin, rsp_item.peak_bin);
               check_field("trough_count", exp_r.trough_count, rsp_item.trough_count);
               check_field("trough_bin", exp_r.trough_bin, rsp_item.trough_bin);
               check_field("bin_low_edge", exp_r.bin_low_edge, rsp_item.bin_low_edge);
            end
         end
         if (start && !busy) begin
            histogram_step(req_item, new_r);
            expected_q.push_back(new_r);
         end
      end
   end

endmodule

### tb/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Binned histogram engine testbench
// Drives directed and random add, query and clear transactions through a
// series of register settings; a separate checker predicts every result.
// ----------------------------------------------------------------------------
module tb_top;
   import bhe_pkg::*;

   localparam int CYCLE_LIMIT = 3000000;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  start = 1'b0;
   logic                  busy;
   req_item_type          req_item = '0;
   logic                  rsp_valid;
   rsp_item_type          rsp_item;
   logic                  csr_we = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;
   int                    fail_count;
   int                    pending;
   int                    cycle_count = 0;
   int                    sent = 0;

   always #2 clock = ~clock;

   binned_histogram_engine u_top (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_item(req_item), .rsp_valid(rsp_valid), .rsp_item(rsp_item),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   bhe_checker u_checker (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_item(req_item), .rsp_valid(rsp_valid), .rsp_item(rsp_item),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata),
      .fail_count(fail_count), .pending(pending)
   );

   // Watchdog: a hung handshake ends the run as a failure.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("TB_ERROR");
         $finish;
      end
   end

   // Presents one transaction and holds it until the block accepts it. The
   // start line is lowered only when a gap follows, so back-to-back
   // transactions never see start lowered and raised within one time step.
   task automatic send(input req_item_type item);
      req_item <= item;
      start    <= 1'b1;
      do @(posedge clock); while (busy);
      sent++;
      // Roughly a third of transactions are followed by an idle gap, except
      // inside one long stretch where the block is fed back to back.
      if ((sent < 700 || sent > 1000) && $urandom_range(99) < 32) begin
         start <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
      end
   endtask

   // Registers may only change while the block is idle: every expected
   // result has arrived and busy has dropped. A short settling wait follows.
   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] data);
      start <= 1'b0;
      do @(posedge clock); while (pending != 0 || busy);
      repeat (4) @(posedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   function automatic req_item_type make_req(input logic [REQ_W-1:0] kind,
                                             input logic [VALUE_W-1:0] value,
                                             input logic [QUERY_W-1:0] qbin);
      req_item_type r;
      r.req_type     = kind;
      r.sample_value = value;
      r.query_bin    = qbin;
      return r;
   endfunction

   // Random transaction: mostly adds landing around the configured range,
   // queries across and just past the bins in use, a few clears and the
   // unused request code.
   task automatic send_random(input int lo, input int hi);
      req_item_type r;
      int pick;
      int vmin;
      int vmax;
      r = make_req(REQ_ADD, 16'($urandom), 9'($urandom));
      pick = $urandom_range(99);
      if (pick < 62) begin
         vmin = (lo < hi) ? lo : hi;
         vmax = (lo < hi) ? hi : lo;
         case ($urandom_range(3))
            0: r.sample_value = 16'($urandom);
            1: r.sample_value = 16'($urandom_range(vmax, vmin));
            default: r.sample_value = 16'($urandom_range(
                        (vmax + 8 > 65535) ? 65535 : vmax + 8,
                        (vmin < 8) ? 0 : vmin - 8));
         endcase
      end else if (pick < 92) begin
         r.req_type = REQ_QUERY;
         r.query_bin = ($urandom_range(9) == 0) ? 9'($urandom)
                                                : 9'($urandom_range(256));
      end else if (pick < 96) begin
         r.req_type = REQ_CLEAR;
      end else begin
         r.req_type = 2'd3;
      end
      send(r);
   endtask

   // Register settings for the random phases: bins, range low, range high.
   int phase_bins [9] = '{256, 1, 0, 511, 2, 37, 256, 100, 255};
   int phase_lo   [9] = '{0, 10, 500, 0, 1000, 1000, 0, 40000, 300};
   int phase_hi   [9] = '{256, 20, 600, 65535, 1000, 900, 65535, 2000, 65535};

   initial begin
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed part at the reset settings: empty query, range extremes,
      // last bin, queries beyond the bins in use, clear and the unused code.
      send(make_req(REQ_QUERY, 16'd0, 9'd0));
      send(make_req(REQ_ADD, 16'd0, 9'd0));
      send(make_req(REQ_ADD, 16'hFFFF, 9'd0));
      send(make_req(REQ_ADD, 16'd256, 9'd0));
      send(make_req(REQ_ADD, 16'd255, 9'd0));
      send(make_req(REQ_ADD, 16'd128, 9'd0));
      send(make_req(REQ_ADD, 16'd128, 9'd0));
      send(make_req(REQ_QUERY, 16'd0, 9'd0));
      send(make_req(REQ_QUERY, 16'd128, 9'd128));
      send(make_req(REQ_QUERY, 16'd0, 9'd255));
      send(make_req(REQ_QUERY, 16'd0, 9'd256));
      send(make_req(REQ_QUERY, 16'hFFFF, 9'h1FF));
      send(make_req(2'd3, 16'hFFFF, 9'h1FF));
      send(make_req(REQ_CLEAR, 16'd0, 9'd0));
      send(make_req(REQ_QUERY, 16'd0, 9'd7));
      // Equal limits put every in-range sample in bin 0.
      write_reg(CSR_RANGE_HIGH, 16'd0);
      send(make_req(REQ_ADD, 16'd0, 9'd0));
      send(make_req(REQ_ADD, 16'd1, 9'd0));
      send(make_req(REQ_QUERY, 16'd0, 9'd1));
      // Inverted range and a write to the unused register index.
      write_reg(CSR_RANGE_LOW, 16'd5000);
      write_reg(2'd3, 16'hFFFF);
      send(make_req(REQ_ADD, 16'd4999, 9'd0));
      send(make_req(REQ_ADD, 16'd5000, 9'd0));
      send(make_req(REQ_ADD, 16'd60000, 9'd0));
      send(make_req(REQ_QUERY, 16'd0, 9'd256));

      foreach (phase_bins[p]) begin
         write_reg(CSR_BINS_IN_USE, 16'(phase_bins[p]));
         write_reg(CSR_RANGE_LOW, 16'(phase_lo[p]));
         write_reg(CSR_RANGE_HIGH, 16'(phase_hi[p]));
         repeat (160) send_random(phase_lo[p], phase_hi[p]);
      end

      // Drain outstanding results, then let the block settle.
      start <= 1'b0;
      do @(posedge clock); while (pending != 0);
      repeat (400) @(posedge clock);
      if (fail_count == 0 && pending == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule
